/* hw/rtl/tts_pkg.sv */
// ----------------------------------------------------------------------------
// tts_pkg - shared types and constants for the triangle tangent space block
// Payload structs, sequencer states and datapath widths.
// ----------------------------------------------------------------------------
package tts_pkg;

    // Datapath widths
    localparam int E_W   = 17;           // edge and texture deltas
    localparam int P_W   = 35;           // plane tangent components
    localparam int D_W   = 37;           // rounded normal projection
    localparam int MA_W  = 37;           // multiplier operand a
    localparam int MB_W  = 31;           // multiplier operand b
    localparam int PR_W  = MA_W + MB_W;  // product
    localparam int ACC_W = PR_W + 2;     // accumulator over up to three terms
    localparam int M_W   = 53;           // orthogonalized tangent magnitude
    localparam int SQ_W  = 64;           // square root operand
    localparam int LEN_W = 32;           // vector length
    localparam int NUM_W = 48;           // division dividend
    localparam int Q_W   = 16;           // division quotient

    localparam logic [15:0]        THR_RESET = 16'd17;
    localparam logic signed [15:0] Q_ONE     = 16'sd16384;

    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic signed [15:0] tex_u;
        logic signed [15:0] tex_v;
        logic signed [15:0] norm_x;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_z;
        logic               first_of_mesh;
    } t_vin;

    typedef struct packed {
        logic signed [15:0] tangent_x;
        logic signed [15:0] tangent_y;
        logic signed [15:0] tangent_z;
        logic signed [15:0] bitangent_x;
        logic signed [15:0] bitangent_y;
        logic signed [15:0] bitangent_z;
        logic [1:0]         corner;
        logic               last;
        logic               degenerate;
        logic               zero_tangent;
    } t_vout;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DELTA,
        S_DET,
        S_CHECK,
        S_PL,
        S_DOT,
        S_ROUND,
        S_TN,
        S_TOP,
        S_NORM,
        S_SQ,
        S_SQRT,
        S_DIV,
        S_BIT,
        S_BRND,
        S_OUT
    } t_state;

endpackage

/* hw/rtl/tts_mul.sv */
// ----------------------------------------------------------------------------
// tts_mul - shared signed multiplier
// One registered product per cycle, with the subtract flag carried alongside.
// ----------------------------------------------------------------------------
module tts_mul (
    input  logic                             i_clk,
    input  logic signed [tts_pkg::MA_W-1:0]  i_a,
    input  logic signed [tts_pkg::MB_W-1:0]  i_b,
    input  logic                             i_sub,
    output logic signed [tts_pkg::PR_W-1:0]  o_prod,
    output logic                             o_sub
);
    import tts_pkg::*;

    logic signed [PR_W-1:0] r_prod;
    logic                   r_sub;

    // Register product and its sign of use
    always_ff @(posedge i_clk) begin
        r_prod <= PR_W'(i_a) * PR_W'(i_b);
        r_sub  <= i_sub;
    end

    assign o_prod = r_prod;
    assign o_sub  = r_sub;

endmodule

/* hw/rtl/tts_sqrt.sv */
// ----------------------------------------------------------------------------
// tts_sqrt - iterative integer square root
// Floor root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module tts_sqrt (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [tts_pkg::SQ_W-1:0]         i_x,
    output logic                             o_done,
    output logic [tts_pkg::LEN_W-1:0]        o_root
);
    import tts_pkg::*;

    logic [SQ_W-1:0] r_x;
    logic [SQ_W-1:0] r_r;
    logic [SQ_W-1:0] r_b;
    logic            r_busy;
    logic            r_done;
    logic [SQ_W-1:0] trial;

    assign trial = r_r + r_b;

    // Advance one bit pair of the operand per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_x    <= i_x;
                r_r    <= '0;
                r_b    <= SQ_W'(1) << (SQ_W - 2);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_x >= trial) begin
                    r_x <= r_x - trial;
                    r_r <= (r_r >> 1) + r_b;
                end else begin
                    r_r <= r_r >> 1;
                end
                r_b <= r_b >> 2;
                if (r_b == SQ_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_r[LEN_W-1:0];

endmodule

/* hw/rtl/tts_div.sv */
// ----------------------------------------------------------------------------
// tts_div - restoring divider
// Unsigned quotient of 16 bits, one bit per cycle.
// ----------------------------------------------------------------------------
module tts_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [tts_pkg::NUM_W-1:0]        i_num,
    input  logic [tts_pkg::LEN_W:0]          i_den,
    output logic                             o_done,
    output logic [tts_pkg::Q_W-1:0]          o_quot
);
    import tts_pkg::*;

    localparam int CNT_W = $clog2(Q_W);

    logic [NUM_W-1:0] r_rem;
    logic [NUM_W-1:0] r_dsh;
    logic [Q_W-1:0]   r_q;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    // Compare and subtract the shifted divisor, most significant bit first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= i_num;
                r_dsh  <= NUM_W'(i_den) << (Q_W - 1);
                r_q    <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_rem >= r_dsh) begin
                    r_rem <= r_rem - r_dsh;
                    r_q   <= {r_q[Q_W-2:0], 1'b1};
                end else begin
                    r_q   <= {r_q[Q_W-2:0], 1'b0};
                end
                r_dsh <= r_dsh >> 1;
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(Q_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

/* hw/rtl/triangle_tangent_space_top.sv */
// ----------------------------------------------------------------------------
// triangle_tangent_space_top - per-triangle tangent frame
// Collects three vertices, forms the plane tangent and, for each corner,
// orthogonalizes it against the normal, normalizes it and forms the bitangent.
//
//   channel  direction  handshake              payload
//   in       input      i_in_valid/o_in_ready   i_in_data  (t_vin)
//   out      output     o_out_valid/i_out_ready o_out_data (t_vout)
//   cfg      input      i_cfg_valid/o_cfg_ready i_cfg_data (threshold)
//
// The first two vertices of a triangle are taken in one cycle each.
// The third starts the work for three results, each set by a square root,
// three divisions and the normalizing shifts on top of the shared
// multiplier; a zero-length tangent result and a degenerate triangle
// take a shorter path. The block takes no request until its last result
// is taken; a stalled result holds. Reset is synchronous and clears the
// control state only.
// ----------------------------------------------------------------------------
module triangle_tangent_space_top (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  tts_pkg::t_vin   i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output tts_pkg::t_vout  o_out_data,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [15:0]     i_cfg_data
);
    import tts_pkg::*;

    // Round right shift by 14, half away from zero
    function automatic logic signed [ACC_W-1:0] rnd14(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-1:0] m;
        m = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
        m = (m + ACC_W'(8192)) >> 14;
        return v[ACC_W-1] ? -$signed(m) : $signed(m);
    endfunction

    // Saturate to the unit range
    function automatic logic signed [15:0] clampq(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] lim;
        lim = ACC_W'(Q_ONE);
        if (v > lim) return Q_ONE;
        if (v < -lim) return -Q_ONE;
        return v[15:0];
    endfunction

    // State
    t_state                  r_state, n_state;
    logic [1:0]              r_cnt, n_cnt;
    t_vin                    r_v0, n_v0, r_v1, n_v1, r_v2, n_v2;
    logic [15:0]             r_thr, n_thr;
    logic signed [E_W-1:0]   r_e1 [3], n_e1 [3];
    logic signed [E_W-1:0]   r_e2 [3], n_e2 [3];
    logic signed [E_W-1:0]   r_t1u, n_t1u, r_t1v, n_t1v, r_t2u, n_t2u, r_t2v, n_t2v;
    logic signed [P_W-1:0]   r_pl [3], n_pl [3];
    logic signed [D_W-1:0]   r_d, n_d;
    logic [M_W-1:0]          r_m [3], n_m [3];
    logic                    r_neg [3], n_neg [3];
    logic [M_W-1:0]          r_top, n_top;
    logic [LEN_W-1:0]        r_len, n_len;
    logic signed [15:0]      r_tan [3], n_tan [3];
    logic signed [15:0]      r_bit [3], n_bit [3];
    logic signed [ACC_W-1:0] r_acc, n_acc;
    logic [1:0]              r_step, n_step;
    logic [1:0]              r_idx, n_idx;
    logic [1:0]              r_corner, n_corner;
    logic                    r_degen, n_degen;
    t_vout                   r_out, n_out;
    logic                    r_out_valid, n_out_valid;

    // Datapath wiring
    logic signed [MA_W-1:0]  mul_a;
    logic signed [MB_W-1:0]  mul_b;
    logic                    mul_sub;
    logic [1:0]              n_terms;
    logic                    is_mul;
    logic signed [PR_W-1:0]  w_prod;
    logic                    w_psub;
    logic signed [ACC_W-1:0] acc_base, prod_ext, acc_sum;
    logic signed [15:0]      w_n [3];
    logic                    sqrt_start, sqrt_done;
    logic [LEN_W-1:0]        sqrt_root;
    logic                    div_start, div_done;
    logic [NUM_W-1:0]        div_num;
    logic [Q_W-1:0]          div_quot;
    logic [1:0]              cnt_eff;
    logic [ACC_W-1:0]        det_mag, t_mag;
    logic signed [ACC_W-1:0] t_val;
    logic [M_W-1:0]          top_max;
    logic signed [15:0]      b_val;

    // Normal of the corner being worked on
    always_comb begin
        unique case (r_corner)
            2'd0:    begin w_n[0] = r_v0.norm_x; w_n[1] = r_v0.norm_y; w_n[2] = r_v0.norm_z; end
            2'd1:    begin w_n[0] = r_v1.norm_x; w_n[1] = r_v1.norm_y; w_n[2] = r_v1.norm_z; end
            default: begin w_n[0] = r_v2.norm_x; w_n[1] = r_v2.norm_y; w_n[2] = r_v2.norm_z; end
        endcase
    end

    // Select multiplier operands for the current step
    always_comb begin
        mul_a   = '0;
        mul_b   = '0;
        mul_sub = 1'b0;
        n_terms = 2'd0;
        is_mul  = 1'b0;
        unique case (r_state)
            S_DET: begin
                is_mul  = 1'b1;
                n_terms = 2'd2;
                if (r_step == 2'd0) begin
                    mul_a = MA_W'(r_t1v);
                    mul_b = MB_W'(r_t2u);
                end else begin
                    mul_a   = MA_W'(r_t1u);
                    mul_b   = MB_W'(r_t2v);
                    mul_sub = 1'b1;
                end
            end
            S_PL: begin
                is_mul  = 1'b1;
                n_terms = 2'd2;
                if (r_step == 2'd0) begin
                    mul_a = MA_W'(r_e2[r_idx]);
                    mul_b = MB_W'(r_t1v);
                end else begin
                    mul_a   = MA_W'(r_e1[r_idx]);
                    mul_b   = MB_W'(r_t2v);
                    mul_sub = 1'b1;
                end
            end
            S_DOT: begin
                is_mul  = 1'b1;
                n_terms = 2'd3;
                if (r_step != 2'd3) begin
                    mul_a = MA_W'(r_pl[r_step]);
                    mul_b = MB_W'(w_n[r_step]);
                end
            end
            S_TN: begin
                is_mul  = 1'b1;
                n_terms = 2'd1;
                mul_a   = MA_W'(r_d);
                mul_b   = MB_W'(w_n[r_idx]);
            end
            S_SQ: begin
                is_mul  = 1'b1;
                n_terms = 2'd3;
                if (r_step != 2'd3) begin
                    mul_a = MA_W'($signed({1'b0, r_m[r_step][29:0]}));
                    mul_b = $signed({1'b0, r_m[r_step][29:0]});
                end
            end
            S_BIT: begin
                is_mul  = 1'b1;
                n_terms = 2'd2;
                unique case (r_idx)
                    2'd0: begin
                        if (r_step == 2'd0) begin
                            mul_a = MA_W'(r_tan[1]); mul_b = MB_W'(w_n[2]);
                        end else begin
                            mul_a = MA_W'(r_tan[2]); mul_b = MB_W'(w_n[1]); mul_sub = 1'b1;
                        end
                    end
                    2'd1: begin
                        if (r_step == 2'd0) begin
                            mul_a = MA_W'(r_tan[2]); mul_b = MB_W'(w_n[0]);
                        end else begin
                            mul_a = MA_W'(r_tan[0]); mul_b = MB_W'(w_n[2]); mul_sub = 1'b1;
                        end
                    end
                    default: begin
                        if (r_step == 2'd0) begin
                            mul_a = MA_W'(r_tan[0]); mul_b = MB_W'(w_n[1]);
                        end else begin
                            mul_a = MA_W'(r_tan[1]); mul_b = MB_W'(w_n[0]); mul_sub = 1'b1;
                        end
                    end
                endcase
            end
            default: ;
        endcase
    end

    tts_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .i_sub  (mul_sub),
        .o_prod (w_prod),
        .o_sub  (w_psub)
    );

    tts_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_x     (acc_sum[SQ_W-1:0]),
        .o_done  (sqrt_done),
        .o_root  (sqrt_root)
    );

    assign div_num = NUM_W'({r_m[r_idx][29:0], 15'b0}) + NUM_W'(r_len);

    tts_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   ({r_len, 1'b0}),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Accumulate the previous product
    assign acc_base = (r_step == 2'd1) ? '0 : r_acc;
    assign prod_ext = ACC_W'(w_prod);
    assign acc_sum  = w_psub ? acc_base - prod_ext : acc_base + prod_ext;

    assign det_mag = r_acc[ACC_W-1] ? ACC_W'(-r_acc) : ACC_W'(r_acc);
    assign t_val   = ACC_W'(r_pl[r_idx]) - acc_sum;
    assign t_mag   = t_val[ACC_W-1] ? ACC_W'(-t_val) : ACC_W'(t_val);
    assign b_val   = clampq(rnd14(r_acc));

    always_comb begin
        top_max = r_m[0];
        if (r_m[1] > top_max) top_max = r_m[1];
        if (r_m[2] > top_max) top_max = r_m[2];
    end

    assign cnt_eff = i_in_data.first_of_mesh ? 2'd0 : r_cnt;

    // Sequencer: next state and datapath updates
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_v0        = r_v0;
        n_v1        = r_v1;
        n_v2        = r_v2;
        n_thr       = r_thr;
        n_e1        = r_e1;
        n_e2        = r_e2;
        n_t1u       = r_t1u;
        n_t1v       = r_t1v;
        n_t2u       = r_t2u;
        n_t2v       = r_t2v;
        n_pl        = r_pl;
        n_d         = r_d;
        n_m         = r_m;
        n_neg       = r_neg;
        n_top       = r_top;
        n_len       = r_len;
        n_tan       = r_tan;
        n_bit       = r_bit;
        n_acc       = r_acc;
        n_step      = r_step;
        n_idx       = r_idx;
        n_corner    = r_corner;
        n_degen     = r_degen;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        sqrt_start  = 1'b0;
        div_start   = 1'b0;

        // Take a threshold write
        if (i_cfg_valid) n_thr = i_cfg_data;

        // Step the shared multiplier
        if (is_mul) begin
            if (r_step == n_terms) begin
                n_acc  = acc_sum;
                n_step = 2'd0;
            end else begin
                n_step = r_step + 2'd1;
                if (r_step != 2'd0) n_acc = acc_sum;
            end
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (cnt_eff)
                        2'd0:    begin n_v0 = i_in_data; n_cnt = 2'd1; end
                        2'd1:    begin n_v1 = i_in_data; n_cnt = 2'd2; end
                        default: begin n_v2 = i_in_data; n_cnt = 2'd0; n_state = S_DELTA; end
                    endcase
                end
            end
            S_DELTA: begin
                n_e1[0] = E_W'(r_v1.pos_x) - E_W'(r_v0.pos_x);
                n_e1[1] = E_W'(r_v1.pos_y) - E_W'(r_v0.pos_y);
                n_e1[2] = E_W'(r_v1.pos_z) - E_W'(r_v0.pos_z);
                n_e2[0] = E_W'(r_v2.pos_x) - E_W'(r_v0.pos_x);
                n_e2[1] = E_W'(r_v2.pos_y) - E_W'(r_v0.pos_y);
                n_e2[2] = E_W'(r_v2.pos_z) - E_W'(r_v0.pos_z);
                n_t1u   = E_W'(r_v1.tex_u) - E_W'(r_v0.tex_u);
                n_t1v   = E_W'(r_v1.tex_v) - E_W'(r_v0.tex_v);
                n_t2u   = E_W'(r_v2.tex_u) - E_W'(r_v0.tex_u);
                n_t2v   = E_W'(r_v2.tex_v) - E_W'(r_v0.tex_v);
                n_step  = 2'd0;
                n_state = S_DET;
            end
            S_DET: begin
                if (r_step == n_terms) n_state = S_CHECK;
            end
            S_CHECK: begin
                n_corner = 2'd0;
                n_idx    = 2'd0;
                n_step   = 2'd0;
                if (!(det_mag > ACC_W'(r_thr))) begin
                    n_degen          = 1'b1;
                    n_out            = '0;
                    n_out.degenerate = 1'b1;
                    n_out_valid      = 1'b1;
                    n_state          = S_OUT;
                end else begin
                    n_degen = 1'b0;
                    n_state = S_PL;
                end
            end
            S_PL: begin
                if (r_step == n_terms) begin
                    n_pl[r_idx] = acc_sum[P_W-1:0];
                    if (r_idx == 2'd2) begin
                        n_idx   = 2'd0;
                        n_state = S_DOT;
                    end else begin
                        n_idx = r_idx + 2'd1;
                    end
                end
            end
            S_DOT: begin
                if (r_step == n_terms) n_state = S_ROUND;
            end
            S_ROUND: begin
                n_d     = D_W'(rnd14(r_acc));
                n_idx   = 2'd0;
                n_step  = 2'd0;
                n_state = S_TN;
            end
            S_TN: begin
                if (r_step == n_terms) begin
                    n_m[r_idx]   = t_mag[M_W-1:0];
                    n_neg[r_idx] = t_val[ACC_W-1];
                    if (r_idx == 2'd2) begin
                        n_idx   = 2'd0;
                        n_state = S_TOP;
                    end else begin
                        n_idx = r_idx + 2'd1;
                    end
                end
            end
            S_TOP: begin
                if (top_max == '0) begin
                    n_out              = '0;
                    n_out.corner       = r_corner;
                    n_out.last         = (r_corner == 2'd2);
                    n_out.zero_tangent = 1'b1;
                    n_out_valid        = 1'b1;
                    n_state            = S_OUT;
                end else begin
                    n_top   = top_max;
                    n_state = S_NORM;
                end
            end
            S_NORM: begin
                // Bring the largest magnitude into [2^29, 2^30)
                if (r_top[M_W-1:30] != '0) begin
                    n_top = r_top >> 1;
                    for (int j = 0; j < 3; j++) n_m[j] = r_m[j] >> 1;
                end else if (!r_top[29]) begin
                    n_top = r_top << 1;
                    for (int j = 0; j < 3; j++) n_m[j] = r_m[j] << 1;
                end else begin
                    n_step  = 2'd0;
                    n_state = S_SQ;
                end
            end
            S_SQ: begin
                if (r_step == n_terms) begin
                    sqrt_start = 1'b1;
                    n_state    = S_SQRT;
                end
            end
            S_SQRT: begin
                if (sqrt_done) begin
                    n_len   = sqrt_root;
                    n_idx   = 2'd0;
                    n_step  = 2'd0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (r_step == 2'd0) begin
                    div_start = 1'b1;
                    n_step    = 2'd1;
                end else if (div_done) begin
                    n_tan[r_idx] = r_neg[r_idx] ? -$signed(div_quot) : $signed(div_quot);
                    n_step       = 2'd0;
                    if (r_idx == 2'd2) begin
                        n_idx   = 2'd0;
                        n_state = S_BIT;
                    end else begin
                        n_idx = r_idx + 2'd1;
                    end
                end
            end
            S_BIT: begin
                if (r_step == n_terms) n_state = S_BRND;
            end
            S_BRND: begin
                n_bit[r_idx] = b_val;
                n_step       = 2'd0;
                if (r_idx == 2'd2) begin
                    n_out.tangent_x    = r_tan[0];
                    n_out.tangent_y    = r_tan[1];
                    n_out.tangent_z    = r_tan[2];
                    n_out.bitangent_x  = r_bit[0];
                    n_out.bitangent_y  = r_bit[1];
                    n_out.bitangent_z  = b_val;
                    n_out.corner       = r_corner;
                    n_out.last         = (r_corner == 2'd2);
                    n_out.degenerate   = 1'b0;
                    n_out.zero_tangent = 1'b0;
                    n_out_valid        = 1'b1;
                    n_idx              = 2'd0;
                    n_state            = S_OUT;
                end else begin
                    n_idx   = r_idx + 2'd1;
                    n_state = S_BIT;
                end
            end
            S_OUT: begin
                // Hold the result until taken, then drop or advance
                if (i_out_ready) begin
                    n_out_valid = 1'b0;
                    if (r_corner == 2'd2) begin
                        n_state = S_IDLE;
                    end else begin
                        n_corner = r_corner + 2'd1;
                        n_step   = 2'd0;
                        n_idx    = 2'd0;
                        if (r_degen) begin
                            n_out            = '0;
                            n_out.corner     = r_corner + 2'd1;
                            n_out.last       = (r_corner == 2'd1);
                            n_out.degenerate = 1'b1;
                            n_out_valid      = 1'b1;
                        end else begin
                            n_state = S_DOT;
                        end
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= 2'd0;
            r_thr       <= THR_RESET;
            r_step      <= 2'd0;
            r_idx       <= 2'd0;
            r_corner    <= 2'd0;
            r_degen     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_thr       <= n_thr;
            r_step      <= n_step;
            r_idx       <= n_idx;
            r_corner    <= n_corner;
            r_degen     <= n_degen;
            r_out_valid <= n_out_valid;
        end
        r_v0  <= n_v0;
        r_v1  <= n_v1;
        r_v2  <= n_v2;
        r_e1  <= n_e1;
        r_e2  <= n_e2;
        r_t1u <= n_t1u;
        r_t1v <= n_t1v;
        r_t2u <= n_t2u;
        r_t2v <= n_t2v;
        r_pl  <= n_pl;
        r_d   <= n_d;
        r_m   <= n_m;
        r_neg <= n_neg;
        r_top <= n_top;
        r_len <= n_len;
        r_tan <= n_tan;
        r_bit <= n_bit;
        r_acc <= n_acc;
        r_out <= n_out;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Checks
    a_ready_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !o_out_valid)
        else $error("input ready while a result is pending");

    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.degenerate && o_out_data.zero_tangent))
        else $error("degenerate and zero tangent both set");

    a_norm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQ) |-> ((r_top[M_W-1:30] == '0) && r_top[29]))
        else $error("tangent not normalized before squaring");

    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_len[LEN_W-1:29] != '0))
        else $error("length below normalized range");

endmodule
